[rtl/im2col_pkg.sv]
// im2col address generator: shared widths, register codes, types and clamp helpers
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package im2col_pkg;

  localparam int unsigned MAX_DIM      = 256;
  localparam int unsigned MAX_CHANNELS = 256;
  localparam int unsigned MAX_KERNEL   = 15;

  localparam int unsigned DIM_W      = 9;
  localparam int unsigned KER_W      = 4;
  localparam int unsigned GEO_W      = 8;
  localparam int unsigned IMG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SRC_W      = 32;
  localparam int unsigned DST_W      = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS    = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_IN_WIDTH    = 3'd2,
    REG_KERNEL_DIMS = 3'd3,
    REG_PADDING     = 3'd4,
    REG_STRIDES     = 3'd5,
    REG_OUT_HEIGHT  = 3'd6,
    REG_OUT_WIDTH   = 3'd7
  } cfg_reg_t;

  // clamped geometry handed to the datapath
  typedef struct packed {
    logic [DIM_W-1:0] c;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] oh;
    logic [DIM_W-1:0] ow;
    logic [KER_W-1:0] kh;
    logic [KER_W-1:0] kw;
    logic [GEO_W-1:0] ph;
    logic [GEO_W-1:0] pw;
    logic [GEO_W-1:0] sh;
    logic [GEO_W-1:0] sw;
  } geom_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;   // transaction accepted: capture stage one, step counters
    logic stage2;  // second multiply stage
    logic finish;  // last stage into the output register
  } dp_cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > max_v) begin
      res = max_v;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [KER_W-1:0] clamp_ker(input logic [KER_W-1:0] v);
    logic [KER_W-1:0] res;
    if (v == '0) begin
      res = KER_W'(1);
    end else if (v > KER_W'(MAX_KERNEL)) begin
      res = KER_W'(MAX_KERNEL);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/im2col_cfg.sv]
// im2col configuration registers with zero and oversize clamping
// depends on im2col_pkg
`timescale 1ns / 1ps
`default_nettype none

module im2col_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [im2col_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [im2col_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output im2col_pkg::geom_t                       geom
);

  logic [im2col_pkg::DIM_W-1:0] channels_r, in_height_r, in_width_r;
  logic [im2col_pkg::DIM_W-1:0] out_height_r, out_width_r;
  logic [7:0]                   kernel_dims_r;
  logic [15:0]                  padding_r, strides_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r    <= 9'd1;
      in_height_r   <= 9'd1;
      in_width_r    <= 9'd1;
      kernel_dims_r <= 8'h11;
      padding_r     <= 16'h0000;
      strides_r     <= 16'h0101;
      out_height_r  <= 9'd1;
      out_width_r   <= 9'd1;
    end else if (cfg_we) begin
      case (im2col_pkg::cfg_reg_t'(cfg_index))
        im2col_pkg::REG_CHANNELS:    channels_r    <= cfg_wdata[8:0];
        im2col_pkg::REG_IN_HEIGHT:   in_height_r   <= cfg_wdata[8:0];
        im2col_pkg::REG_IN_WIDTH:    in_width_r    <= cfg_wdata[8:0];
        im2col_pkg::REG_KERNEL_DIMS: kernel_dims_r <= cfg_wdata[7:0];
        im2col_pkg::REG_PADDING:     padding_r     <= cfg_wdata;
        im2col_pkg::REG_STRIDES:     strides_r     <= cfg_wdata;
        im2col_pkg::REG_OUT_HEIGHT:  out_height_r  <= cfg_wdata[8:0];
        im2col_pkg::REG_OUT_WIDTH:   out_width_r   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.c  = im2col_pkg::clamp_dim(channels_r,
                                    im2col_pkg::DIM_W'(im2col_pkg::MAX_CHANNELS));
    geom.h  = im2col_pkg::clamp_dim(in_height_r, im2col_pkg::DIM_W'(im2col_pkg::MAX_DIM));
    geom.w  = im2col_pkg::clamp_dim(in_width_r, im2col_pkg::DIM_W'(im2col_pkg::MAX_DIM));
    geom.oh = im2col_pkg::clamp_dim(out_height_r, im2col_pkg::DIM_W'(im2col_pkg::MAX_DIM));
    geom.ow = im2col_pkg::clamp_dim(out_width_r, im2col_pkg::DIM_W'(im2col_pkg::MAX_DIM));
    geom.kh = im2col_pkg::clamp_ker(kernel_dims_r[7:4]);
    geom.kw = im2col_pkg::clamp_ker(kernel_dims_r[3:0]);
    geom.ph = padding_r[15:8];
    geom.pw = padding_r[7:0];
    geom.sh = strides_r[15:8];
    geom.sw = strides_r[7:0];
  end

endmodule

`default_nettype wire

[rtl/im2col_dp.sv]
// im2col datapath: loop counters, three multiply stages and the output register
// depends on im2col_pkg
`timescale 1ns / 1ps
`default_nettype none

module im2col_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire im2col_pkg::dp_cmd_t               cmd,
  input  wire im2col_pkg::geom_t                 geom,
  input  wire logic [im2col_pkg::IMG_W-1:0]      image_index,
  output logic      [im2col_pkg::SRC_W-1:0]      source_address,
  output logic                                   in_bounds,
  output logic      [im2col_pkg::DST_W-1:0]      dest_address,
  output logic                                   last_of_image
);

  // loop counters
  logic [8:0] oh_cnt_r, ow_cnt_r, ch_cnt_r;
  logic [3:0] kh_cnt_r, kw_cnt_r;
  logic [8:0] oh_cnt_nxt, ow_cnt_nxt, ch_cnt_nxt;
  logic [3:0] kh_cnt_nxt, kw_cnt_nxt;
  logic       kw_wrap, kh_wrap, ch_wrap, ow_wrap, oh_wrap, last_nxt;

  assign kw_wrap = ({1'b0, kw_cnt_r} + 5'd1) >= {1'b0, geom.kw};
  assign kh_wrap = ({1'b0, kh_cnt_r} + 5'd1) >= {1'b0, geom.kh};
  assign ch_wrap = ({1'b0, ch_cnt_r} + 10'd1) >= {1'b0, geom.c};
  assign ow_wrap = ({1'b0, ow_cnt_r} + 10'd1) >= {1'b0, geom.ow};
  assign oh_wrap = ({1'b0, oh_cnt_r} + 10'd1) >= {1'b0, geom.oh};
  assign last_nxt = kw_wrap & kh_wrap & ch_wrap & ow_wrap & oh_wrap;

  always_comb begin
    kw_cnt_nxt = kw_wrap ? 4'd0 : kw_cnt_r + 4'd1;
    kh_cnt_nxt = kh_cnt_r;
    ch_cnt_nxt = ch_cnt_r;
    ow_cnt_nxt = ow_cnt_r;
    oh_cnt_nxt = oh_cnt_r;
    if (kw_wrap) begin
      kh_cnt_nxt = kh_wrap ? 4'd0 : kh_cnt_r + 4'd1;
      if (kh_wrap) begin
        ch_cnt_nxt = ch_wrap ? 9'd0 : ch_cnt_r + 9'd1;
        if (ch_wrap) begin
          ow_cnt_nxt = ow_wrap ? 9'd0 : ow_cnt_r + 9'd1;
          if (ow_wrap) begin
            oh_cnt_nxt = oh_wrap ? 9'd0 : oh_cnt_r + 9'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oh_cnt_r <= '0;
      ow_cnt_r <= '0;
      ch_cnt_r <= '0;
      kh_cnt_r <= '0;
      kw_cnt_r <= '0;
    end else if (cmd.start) begin
      oh_cnt_r <= oh_cnt_nxt;
      ow_cnt_r <= ow_cnt_nxt;
      ch_cnt_r <= ch_cnt_nxt;
      kh_cnt_r <= kh_cnt_nxt;
      kw_cnt_r <= kw_cnt_nxt;
    end
  end

  // stage one: products of the current counters
  logic [16:0] oh_sh, ow_sw, n_c, n_oh;
  logic [12:0] c_kh;
  logic [7:0]  kk_nxt;
  logic [18:0] ih_nxt, iw_nxt;
  logic [17:0] p1_nxt, r1_nxt;
  logic [13:0] c1_nxt;

  assign oh_sh  = 17'(oh_cnt_r) * 17'(geom.sh);
  assign ow_sw  = 17'(ow_cnt_r) * 17'(geom.sw);
  assign n_c    = 17'(image_index) * 17'(geom.c);
  assign n_oh   = 17'(image_index) * 17'(geom.oh);
  assign c_kh   = 13'(ch_cnt_r) * 13'(geom.kh);
  assign kk_nxt = 8'(geom.kh) * 8'(geom.kw);
  // two's complement, bit 18 set means above the top or left edge
  assign ih_nxt = {2'b00, oh_sh} + {15'd0, kh_cnt_r} - {11'd0, geom.ph};
  assign iw_nxt = {2'b00, ow_sw} + {15'd0, kw_cnt_r} - {11'd0, geom.pw};
  assign p1_nxt = {1'b0, n_c} + {9'd0, ch_cnt_r};
  assign r1_nxt = {1'b0, n_oh} + {9'd0, oh_cnt_r};
  assign c1_nxt = {1'b0, c_kh} + {10'd0, kh_cnt_r};

  logic [17:0] p1_r, r1_r;
  logic [18:0] ih_r, iw_r;
  logic [13:0] c1_r;
  logic [7:0]  kk_r;
  logic [3:0]  kw_s1_r;
  logic [8:0]  ow_s1_r;
  logic        last_s1_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p1_r      <= p1_nxt;
      r1_r      <= r1_nxt;
      ih_r      <= ih_nxt;
      iw_r      <= iw_nxt;
      c1_r      <= c1_nxt;
      kk_r      <= kk_nxt;
      kw_s1_r   <= kw_cnt_r;
      ow_s1_r   <= ow_cnt_r;
      last_s1_r <= last_nxt;
    end
  end

  // stage two: bounds check and second products
  logic        inside_nxt;
  logic [26:0] p1_h, r1_ow;
  logic [17:0] c1_kw;
  logic [27:0] p2_nxt, r2_nxt;
  logic [18:0] col_nxt;
  logic [16:0] win_nxt;

  assign inside_nxt = !ih_r[18] && (ih_r[17:0] < {9'd0, geom.h}) &&
                      !iw_r[18] && (iw_r[17:0] < {9'd0, geom.w});
  assign p1_h    = 27'(p1_r) * 27'(geom.h);
  assign r1_ow   = 27'(r1_r) * 27'(geom.ow);
  assign c1_kw   = 18'(c1_r) * 18'(geom.kw);
  assign p2_nxt  = {1'b0, p1_h} + {19'd0, ih_r[8:0]};
  assign r2_nxt  = {1'b0, r1_ow} + {19'd0, ow_s1_r};
  assign col_nxt = {1'b0, c1_kw} + {15'd0, kw_s1_r};
  assign win_nxt = 17'(geom.c) * 17'(kk_r);

  logic [27:0] p2_r, r2_r;
  logic [18:0] col_r;
  logic [16:0] win_r;
  logic [8:0]  iw_s2_r;
  logic        inside_r, last_s2_r;

  always_ff @(posedge clk) begin
    if (cmd.stage2) begin
      p2_r      <= p2_nxt;
      r2_r      <= r2_nxt;
      col_r     <= col_nxt;
      win_r     <= win_nxt;
      iw_s2_r   <= iw_r[8:0];
      inside_r  <= inside_nxt;
      last_s2_r <= last_s1_r;
    end
  end

  // stage three: final products into the output register
  logic [36:0] p2_w;
  logic [44:0] r2_win;
  logic [36:0] src_full;
  logic [im2col_pkg::SRC_W-1:0] src_nxt;
  logic [im2col_pkg::DST_W-1:0] dst_nxt;

  assign p2_w     = 37'(p2_r) * 37'(geom.w);
  assign r2_win   = 45'(r2_r) * 45'(win_r);
  assign src_full = p2_w + {28'd0, iw_s2_r};
  assign src_nxt  = inside_r ? src_full[im2col_pkg::SRC_W-1:0] : '0;
  assign dst_nxt  = {3'd0, r2_win} + {29'd0, col_r};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      source_address <= src_nxt;
      in_bounds      <= inside_r;
      dest_address   <= dst_nxt;
      last_of_image  <= last_s2_r;
    end
  end

endmodule

`default_nettype wire

[rtl/im2col_ctrl.sv]
// im2col controller: sequences the three datapath stages and owns both handshakes
// depends on im2col_pkg
`timescale 1ns / 1ps
`default_nettype none

module im2col_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output im2col_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL2 = 3'b010,
    ST_MUL3 = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd.start  = 1'b0;
    cmd.stage2 = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.stage2 = 1'b1;
        state_nxt  = ST_MUL3;
      end
      ST_MUL3: begin
        // wait here while the previous result is stalled
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/im2col_address_generator.sv]
// im2col address generator top level: configuration registers, controller, datapath
// depends on im2col_pkg, im2col_cfg, im2col_ctrl and im2col_dp
`timescale 1ns / 1ps
`default_nettype none

// usage
//   cfg port: write cfg_wdata into register cfg_index while cfg_we is high; no read-back.
//     write only while the block is idle; unknown codes do not exist on a 3-bit index
//   in channel: one transaction per element of the im2col walk, carrying the batch index.
//     the element is picked by internal counters (output row, output column, channel,
//     kernel row, kernel column, innermost last) which step on every transaction and
//     wrap to zero after the final element of the image
//   out channel: source address, in-bounds flag (clear means write zero), column-matrix
//     address and last-of-image flag for that element
//   path: an accepted transaction runs through the three datapath multiply stages
//     (one multiplier deep each) into the output register, which raises out_valid
//   pacing: the controller takes one transaction at a time; in_ready is high only
//     between elements, not again until the last one is in the output register
//   stall: a finished result sits in the output register; the next element is accepted
//     and computed behind it and waits in its last stage until out_ready frees the slot
//   reset: synchronous active-low; registers return to their defaults, counters to
//     zero, out_valid drops and in_ready is high on the first cycle after reset
module im2col_address_generator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [im2col_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [im2col_pkg::IMG_W-1:0]        in_image_index,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [im2col_pkg::SRC_W-1:0]        out_source_address,
  output logic                                     out_in_bounds,
  output logic      [im2col_pkg::DST_W-1:0]        out_dest_address,
  output logic                                     out_last_of_image
);

  im2col_pkg::geom_t   geom;
  im2col_pkg::dp_cmd_t cmd;

  // register file; values reach the datapath already clamped
  im2col_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  // sequencer: accept with stage-one capture, second multiply stage, output load
  im2col_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // loop counters and address arithmetic; counters step on the accepting edge
  im2col_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .geom           (geom),
    .image_index    (in_image_index),
    .source_address (out_source_address),
    .in_bounds      (out_in_bounds),
    .dest_address   (out_dest_address),
    .last_of_image  (out_last_of_image)
  );

`ifndef SYNTHESIS
  // an element reaches the output through stage one and stage two when the slot is free
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##2 (!out_valid || out_ready) |=> out_valid)
    else $error("result missing three cycles after transaction");

  // a fresh result only ever follows an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result without a matching input transaction");

  // padding elements carry a zero source address
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_bounds) |-> (out_source_address == '0))
    else $error("nonzero source address on padding element");

  // no new transaction while an element is still in the stages
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("transaction accepted while busy");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// self-checking testbench for the im2col address generator
// depends on im2col_pkg and im2col_address_generator; predicts every element descriptor
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import im2col_pkg::*;

  localparam int RANDOM_STEPS = 1130;
  localparam int DRAIN_CYCLES = 6;       // extra wait once every expected result has been seen
  localparam int CYCLE_LIMIT  = 400000;

  // one element descriptor as seen on the out channel
  typedef struct packed {
    logic [SRC_W-1:0] source;
    logic             in_bounds;
    logic [DST_W-1:0] dest;
    logic             last_flag;
  } elem_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // a directed row is either a register write or one step of the walk
  typedef struct {
    row_kind_t        kind;
    cfg_reg_t         which;
    logic [15:0]      data;
    logic [IMG_W-1:0] image;
    bit               typed;
    elem_t            want;
  } dir_row_t;

  localparam elem_t NO_WANT = '0;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IMG_W-1:0]      in_image_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SRC_W-1:0]      out_source_address;
  logic                  out_in_bounds;
  logic [DST_W-1:0]      out_dest_address;
  logic                  out_last_of_image;

  im2col_address_generator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_image_index     (in_image_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_source_address (out_source_address),
    .out_in_bounds      (out_in_bounds),
    .out_dest_address   (out_dest_address),
    .out_last_of_image  (out_last_of_image)
  );

  // predictor copy of the geometry registers, at reset values
  logic [8:0]  geo_channels    = 9'd1;
  logic [8:0]  geo_in_height   = 9'd1;
  logic [8:0]  geo_in_width    = 9'd1;
  logic [7:0]  geo_kernel_dims = 8'h11;
  logic [15:0] geo_padding     = 16'h0000;
  logic [15:0] geo_strides     = 16'h0101;
  logic [8:0]  geo_out_height  = 9'd1;
  logic [8:0]  geo_out_width   = 9'd1;

  // predictor copy of the loop counters, outermost first
  logic [8:0] oh_cnt = '0;
  logic [8:0] ow_cnt = '0;
  logic [8:0] ch_cnt = '0;
  logic [3:0] kh_cnt = '0;
  logic [3:0] kw_cnt = '0;

  elem_t expected_elems[$];
  int    fail_count = 0;
  bit    no_gaps = 1'b0;     // set during the stretch with no idling on either side
  int    cycle_count;

  // directed stimulus: typed expectations only where the answer is obvious
  dir_row_t dir_rows[$] = '{
    // after reset every size is one: source and dest both equal the image index
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h00, 1'b1, '{32'd0,   1'b1, 48'd0,   1'b1}},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'hFF, 1'b1, '{32'd255, 1'b1, 48'd255, 1'b1}},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h5A, 1'b1, '{32'd90,  1'b1, 48'd90,  1'b1}},
    // small padded 3x3 image, two channels, 2x2 kernel
    '{ROW_CFG,  REG_CHANNELS,    16'd2,    8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_IN_HEIGHT,   16'd3,    8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_IN_WIDTH,    16'd3,    8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_KERNEL_DIMS, 16'h0022, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_PADDING,     16'h0101, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_STRIDES,     16'h0101, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_OUT_HEIGHT,  16'd3,    8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_OUT_WIDTH,   16'd3,    8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h0F, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h0F, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h0F, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h0F, 1'b0, NO_WANT},
    // shrink channels mid-image: channel counter now sits past its bound
    '{ROW_CFG,  REG_CHANNELS,    16'd1,    8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h0F, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h0F, 1'b0, NO_WANT},
    // all ones: every size clamps to its maximum, pads and strides at 255
    '{ROW_CFG,  REG_CHANNELS,    16'hFFFF, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_IN_HEIGHT,   16'hFFFF, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_IN_WIDTH,    16'hFFFF, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_KERNEL_DIMS, 16'hFFFF, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_PADDING,     16'hFFFF, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_STRIDES,     16'hFFFF, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_OUT_HEIGHT,  16'hFFFF, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_OUT_WIDTH,   16'hFFFF, 8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'hFF, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'hFF, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'hFF, 1'b0, NO_WANT},
    // all zeros: sizes read as one, zero stride, no padding
    '{ROW_CFG,  REG_CHANNELS,    16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_IN_HEIGHT,   16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_IN_WIDTH,    16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_KERNEL_DIMS, 16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_PADDING,     16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_STRIDES,     16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_OUT_HEIGHT,  16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_OUT_WIDTH,   16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h00, 1'b0, NO_WANT},
    // zero stride with a 1x2 kernel on two output columns: a short image that wraps
    '{ROW_CFG,  REG_KERNEL_DIMS, 16'h0012, 8'h00, 1'b0, NO_WANT},
    '{ROW_CFG,  REG_OUT_WIDTH,   16'd2,    8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h81, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h81, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h81, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h81, 1'b0, NO_WANT},
    '{ROW_ITEM, REG_CHANNELS, 16'h0000, 8'h81, 1'b0, NO_WANT}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // size as the block uses it: zero reads as one, anything too big as the cap
  function automatic longint fit_size(input longint v, input longint cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  // descriptor of the element at the current counters, then step the loop nest
  function automatic elem_t walk_element(input logic [IMG_W-1:0] image);
    longint n, cs, hs, ws, ohs, ows, khs, kws, ph, pw, sh, sw;
    longint oh, ow, ch, kh, kw, ih, iw, win, full;
    elem_t  e;
    bit     carry;
    n   = image;
    cs  = fit_size(geo_channels, MAX_CHANNELS);
    hs  = fit_size(geo_in_height, MAX_DIM);
    ws  = fit_size(geo_in_width, MAX_DIM);
    ohs = fit_size(geo_out_height, MAX_DIM);
    ows = fit_size(geo_out_width, MAX_DIM);
    khs = fit_size(geo_kernel_dims[7:4], MAX_KERNEL);
    kws = fit_size(geo_kernel_dims[3:0], MAX_KERNEL);
    ph  = geo_padding[15:8];
    pw  = geo_padding[7:0];
    sh  = geo_strides[15:8];
    sw  = geo_strides[7:0];
    oh  = oh_cnt;
    ow  = ow_cnt;
    ch  = ch_cnt;
    kh  = kh_cnt;
    kw  = kw_cnt;

    // padded input coordinate; negative or past the edge means write zero
    ih = oh * sh + kh - ph;
    iw = ow * sw + kw - pw;
    e.in_bounds = (ih >= 0) && (ih < hs) && (iw >= 0) && (iw < ws);
    e.source = '0;
    if (e.in_bounds) begin
      full = ((n * cs + ch) * hs + ih) * ws + iw;
      e.source = full[SRC_W-1:0];
    end
    win = cs * khs * kws;
    full = ((n * ohs + oh) * ows + ow) * win + (ch * khs + kh) * kws + kw;
    e.dest = full[DST_W-1:0];

    // innermost first; a counter at or past its bound wraps and carries outward
    carry = 1'b1;
    if (kw + 1 >= kws) kw_cnt = '0;
    else begin
      kw_cnt = kw_cnt + 1'b1;
      carry = 1'b0;
    end
    if (carry) begin
      if (kh + 1 >= khs) kh_cnt = '0;
      else begin
        kh_cnt = kh_cnt + 1'b1;
        carry = 1'b0;
      end
    end
    if (carry) begin
      if (ch + 1 >= cs) ch_cnt = '0;
      else begin
        ch_cnt = ch_cnt + 1'b1;
        carry = 1'b0;
      end
    end
    if (carry) begin
      if (ow + 1 >= ows) ow_cnt = '0;
      else begin
        ow_cnt = ow_cnt + 1'b1;
        carry = 1'b0;
      end
    end
    if (carry) begin
      if (oh + 1 >= ohs) oh_cnt = '0;
      else begin
        oh_cnt = oh_cnt + 1'b1;
        carry = 1'b0;
      end
    end
    e.last_flag = carry;
    return e;
  endfunction

  // register value for a random phase: mostly small geometry, sometimes raw bits
  function automatic logic [15:0] pick_value(input cfg_reg_t which);
    int          roll;
    logic [15:0] v;
    roll = $urandom_range(0, 31);
    if (roll == 0) v = 16'h0000;
    else if (roll == 1) v = 16'hFFFF;
    else if (roll < 4) v = 16'($urandom);
    else begin
      case (which)
        REG_CHANNELS:                  v = 16'($urandom_range(1, 3));
        REG_IN_HEIGHT, REG_IN_WIDTH:   v = 16'($urandom_range(1, 6));
        REG_OUT_HEIGHT, REG_OUT_WIDTH: v = 16'($urandom_range(1, 3));
        REG_KERNEL_DIMS: v = {8'h00, 4'($urandom_range(1, 3)), 4'($urandom_range(1, 3))};
        REG_PADDING:     v = {8'($urandom_range(0, 2)), 8'($urandom_range(0, 2))};
        default:         v = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
      endcase
    end
    return v;
  endfunction

  // idle decision shared by both sides, about a quarter of the time
  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(0, 99) < 25);
  endfunction

  // register write; the predictor copy changes at the same edge as the block
  task automatic write_reg(input cfg_reg_t which, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      REG_CHANNELS:    geo_channels    = value[8:0];
      REG_IN_HEIGHT:   geo_in_height   = value[8:0];
      REG_IN_WIDTH:    geo_in_width    = value[8:0];
      REG_KERNEL_DIMS: geo_kernel_dims = value[7:0];
      REG_PADDING:     geo_padding     = value;
      REG_STRIDES:     geo_strides     = value;
      REG_OUT_HEIGHT:  geo_out_height  = value[8:0];
      default:         geo_out_width   = value[8:0];
    endcase
  endtask

  // one in transaction; returns at the accepting edge with valid still high
  task automatic send_step(input logic [IMG_W-1:0] image, input bit typed,
                           input elem_t want, output elem_t got);
    if (take_gap()) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_image_index <= image;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = walk_element(image);
    expected_elems.push_back(typed ? want : got);
  endtask

  // drop valid and let the block drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random back-pressure, none during the steady stretch
  always @(posedge clk) begin
    out_ready <= !take_gap();
  end

  // out channel checker against the oldest expectation
  always @(posedge clk) begin
    elem_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_source_address, out_in_bounds, out_dest_address, out_last_of_image};
      if (expected_elems.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected transaction: src=%h inb=%b dst=%h last=%b",
                   got.source, got.in_bounds, got.dest, got.last_flag);
      end else begin
        want = expected_elems.pop_front();
        if (got.source !== want.source || got.in_bounds !== want.in_bounds ||
            got.dest !== want.dest || got.last_flag !== want.last_flag) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: want src=%h inb=%b dst=%h last=%b, got src=%h inb=%b dst=%h last=%b",
                     want.source, want.in_bounds, want.dest, want.last_flag,
                     got.source, got.in_bounds, got.dest, got.last_flag);
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  // main sequence: reset, directed table, random phases, drain, verdict
  initial begin
    int               done;
    int               phase_len;
    bit               prev_item;
    logic [IMG_W-1:0] image;
    logic [IMG_W-1:0] held_image;
    cfg_reg_t         which;
    elem_t            got;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part; writes wait for the block to go idle
    prev_item = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (prev_item) settle();
        write_reg(dir_rows[i].which, dir_rows[i].data);
        prev_item = 1'b0;
      end else begin
        send_step(dir_rows[i].image, dir_rows[i].typed, dir_rows[i].want, got);
        prev_item = 1'b1;
      end
    end

    // random phases: new geometry, then well-formed images with some noise
    done = 0;
    held_image = IMG_W'($urandom_range(0, 255));
    while (done < RANDOM_STEPS) begin
      settle();
      which = which.first();
      repeat (which.num()) begin
        if ($urandom_range(0, 1) == 1) write_reg(which, pick_value(which));
        which = which.next();
      end
      phase_len = $urandom_range(8, 50);
      repeat (phase_len) begin
        // the batch index is held for an image, except for the odd stray one
        if ($urandom_range(0, 9) == 0) image = IMG_W'($urandom);
        else image = held_image;
        send_step(image, 1'b0, NO_WANT, got);
        if (got.last_flag) held_image = IMG_W'($urandom_range(0, 255));
        done++;
        no_gaps = (done >= 400) && (done < 650);
      end
    end
    no_gaps = 1'b0;

    settle();
    if (fail_count == 0 && expected_elems.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/im2col_pkg.sv
rtl/im2col_cfg.sv
rtl/im2col_dp.sv
rtl/im2col_ctrl.sv
rtl/im2col_address_generator.sv
tb/tb.sv
